// ===== design/sbpwm_pkg.sv =====
`default_nettype none
package sbpwm_pkg;
    localparam int SERVO_COUNT_DEF = 8;
    localparam int RESULT_LIMIT = 8;

    typedef enum logic [2:0] {
        REQ_REGISTER = 3'd0, REQ_SET_POS = 3'd1, REQ_OPEN = 3'd2, REQ_CLOSE = 3'd3,
        REQ_SET_CLOSED = 3'd4, REQ_SET_OPENED = 3'd5, REQ_DISABLE = 3'd6, REQ_TICK = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_CH_HIGH = 3'd1, ST_NOT_REG = 3'd2, ST_LIMITS = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    localparam logic [2:0] CFG_MIN = 3'd0;
    localparam logic [2:0] CFG_MAX = 3'd1;
    localparam logic [2:0] CFG_FREQ = 3'd2;
    localparam logic [2:0] CFG_RANGE = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  channel;
        logic [15:0] position;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_channel;
        logic        compare_written;
        logic [15:0] compare_value;
        logic [15:0] current_position;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] min_pulse_us;
        logic [15:0] max_pulse_us;
        logic [9:0]  pwm_frequency_hz;
        logic [15:0] position_range;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]  req_type;
        logic        ch_high;
        logic [7:0]  channel;
        logic [15:0] position;
    } t_cmd;
endpackage
`default_nettype wire

// ===== design/sbpwm_front.sv =====
`default_nettype none
module sbpwm_front #(
    parameter int SERVO_COUNT = 8,
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire sbpwm_pkg::t_in i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output sbpwm_pkg::t_cmd     o_cmd
);
    import sbpwm_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd           r_q [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    t_cmd           w_cmd;
    logic           w_push, w_pop;

    // classify request: flag channels outside the bank
    always_comb begin
        w_cmd.req_type = i_data.req_type;
        w_cmd.channel  = i_data.channel;
        w_cmd.position = i_data.position;
        w_cmd.ch_high  = ({1'b0, i_data.channel} >= 9'(SERVO_COUNT)) &&
                         (i_data.req_type != REQ_TICK);
    end

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    // advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ===== design/sbpwm_back.sv =====
`default_nettype none
module sbpwm_back #(
    parameter int SERVO_COUNT = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire sbpwm_pkg::t_cfg i_cfg,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire sbpwm_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire                 i_ready,
    output sbpwm_pkg::t_out     o_data,
    output logic                o_busy
);
    import sbpwm_pkg::*;
    localparam int CW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001, S_DECODE = 10'b00_0000_0010,
        S_MUL   = 10'b00_0000_0100, S_DIV    = 10'b00_0000_1000,
        S_CMP   = 10'b00_0001_0000, S_CMP2   = 10'b00_0010_0000,
        S_SCALE = 10'b00_0100_0000, S_RECIP  = 10'b00_1000_0000,
        S_TICK  = 10'b01_0000_0000, S_OUT    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [SERVO_COUNT-1:0] r_reg;
    logic [15:0] r_open [SERVO_COUNT];
    logic [15:0] r_close[SERVO_COUNT];
    logic [15:0] r_pos  [SERVO_COUNT];
    logic [15:0] r_tmo  [SERVO_COUNT];
    logic [15:0] r_cmp  [SERVO_COUNT];

    logic [CW-1:0] r_ch;
    logic [CW:0]   r_idx;
    logic [3:0]    r_nres;
    logic [15:0]   r_tpos;
    logic          r_neg;
    logic [32:0]   r_num;     // |pos*diff|, then quotient
    logic [16:0]   r_rem;
    logic [5:0]    r_bit;
    logic [15:0]   r_width;
    logic [25:0]   r_prod;
    logic [31:0]   r_scaled;
    t_out          r_out;
    t_out          r_hold;
    logic          r_have;
    logic          r_ovalid;

    logic [CW-1:0] w_ch;
    logic [15:0]   w_lo, w_hi, w_tgt;
    logic [16:0]   w_diff;
    logic [16:0]   w_adiff;
    logic [17:0]   w_trial;
    logic [63:0]   w_recip;
    logic [15:0]   w_cmpv;
    logic [CW-1:0] w_tch;
    logic          w_tend, w_hit, w_rep, w_tsend, w_tstall, w_emit;
    t_out          w_fin;

    assign w_ch   = r_cmd.channel[CW-1:0];
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_busy  = (r_state != S_IDLE) || r_ovalid;

    always_comb begin
        w_lo  = (r_close[w_ch] < r_open[w_ch]) ? r_close[w_ch] : r_open[w_ch];
        w_hi  = (r_close[w_ch] > r_open[w_ch]) ? r_close[w_ch] : r_open[w_ch];
        w_diff = {1'b0, i_cfg.max_pulse_us} - {1'b0, i_cfg.min_pulse_us};
        w_adiff = w_diff[16] ? (~w_diff + 17'd1) : w_diff;
        w_trial = {r_rem, r_num[32]} - {2'b0, i_cfg.position_range};
        unique case (r_cmd.req_type)
            REQ_OPEN:  w_tgt = r_open[w_ch];
            REQ_CLOSE: w_tgt = r_close[w_ch];
            default:   w_tgt = r_cmd.position;
        endcase
    end

    // divide by 1000000 through a reciprocal multiply, exact for 32-bit dividends
    assign w_recip = {32'b0, r_scaled} * 64'd1125899907;
    assign w_cmpv  = {2'b0, w_recip[63:50]};

    // tick walk: a result goes out when the next one is known or the walk ends
    assign w_tch    = r_idx[CW-1:0];
    assign w_tend   = (r_idx == (CW+1)'(SERVO_COUNT));
    assign w_hit    = !w_tend && r_reg[w_tch] && (r_tmo[w_tch] == 16'd1);
    assign w_rep    = w_hit && (r_nres != 4'(RESULT_LIMIT));
    assign w_tsend  = (r_state == S_TICK) && r_have && (w_tend || w_rep);
    assign w_tstall = w_tsend && r_ovalid && !i_ready;
    assign w_emit   = (r_state == S_OUT) || (w_tsend && !w_tstall);

    always_comb begin
        w_fin = r_hold;
        w_fin.last = 1'b1;
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_emit) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_have   <= 1'b0;
            r_reg    <= '0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_open[i] <= '0; r_close[i] <= '0; r_pos[i] <= '0;
                r_tmo[i] <= '0; r_cmp[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_nres  <= '0;
                        r_have  <= 1'b0;
                        r_state <= (i_cmd.req_type == REQ_TICK) ? S_TICK : S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_ch <= w_ch;
                    r_out.result_channel  <= r_cmd.channel;
                    r_out.last            <= 1'b1;
                    r_out.compare_written <= 1'b0;
                    r_state <= S_OUT;
                    if (r_cmd.ch_high) begin
                        r_out.status <= ST_CH_HIGH;
                        r_out.compare_value <= '0;
                        r_out.current_position <= '0;
                    end else begin
                        r_out.status <= ST_OK;
                        r_out.compare_value <= r_cmp[w_ch];
                        r_out.current_position <= r_pos[w_ch];
                        if (r_cmd.req_type == REQ_REGISTER) begin
                            r_reg[w_ch]   <= 1'b1;
                            r_close[w_ch] <= '0;
                            r_open[w_ch]  <= i_cfg.position_range;
                            r_tpos  <= '0;
                            r_state <= S_MUL;
                        end else if (!r_reg[w_ch]) begin
                            r_out.status <= ST_NOT_REG;
                        end else begin
                            case (r_cmd.req_type)
                                REQ_SET_POS, REQ_OPEN, REQ_CLOSE: begin
                                    if (w_tgt > w_hi || w_tgt < w_lo)
                                        r_out.status <= ST_LIMITS;
                                    else begin
                                        r_tpos  <= w_tgt;
                                        r_state <= S_MUL;
                                    end
                                end
                                REQ_SET_CLOSED, REQ_SET_OPENED: begin
                                    if (r_cmd.position > i_cfg.position_range)
                                        r_out.status <= ST_RANGE;
                                    else if (r_cmd.req_type == REQ_SET_CLOSED)
                                        r_close[w_ch] <= r_cmd.position;
                                    else
                                        r_open[w_ch] <= r_cmd.position;
                                end
                                default: begin
                                    r_cmp[w_ch] <= '0;
                                    r_out.compare_value <= '0;
                                    r_out.compare_written <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                // magnitude of pos*diff, one 16x17 multiply
                S_MUL: begin
                    r_num   <= (i_cfg.position_range == '0) ? '0 :
                               {16'b0, r_tpos} * {16'b0, w_adiff};
                    r_neg   <= w_diff[16];
                    r_rem   <= '0;
                    r_bit   <= 6'd33;
                    r_state <= (i_cfg.position_range == '0) ? S_CMP : S_DIV;
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (!w_trial[17]) begin
                        r_rem <= w_trial[16:0];
                        r_num <= {r_num[31:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[15:0], r_num[32]};
                        r_num <= {r_num[31:0], 1'b0};
                    end
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd1) r_state <= S_CMP;
                end
                S_CMP: begin
                    r_width <= i_cfg.min_pulse_us +
                               (r_neg ? (~r_num[15:0] + 16'd1) : r_num[15:0]);
                    r_state <= S_CMP2;
                end
                // width*freq fits 26 bits
                S_CMP2: begin
                    r_prod  <= {10'b0, r_width} * {16'b0, i_cfg.pwm_frequency_hz};
                    r_state <= S_SCALE;
                end
                // scale by 1000, keeping the low 32 bits
                S_SCALE: begin
                    r_scaled <= 32'({10'b0, r_prod} * 36'd1000);
                    r_state  <= S_RECIP;
                end
                S_RECIP: begin
                    r_cmp[r_ch]  <= w_cmpv;
                    r_pos[r_ch]  <= r_tpos;
                    r_tmo[r_ch]  <= i_cfg.timeout_ticks;
                    r_out.compare_value <= w_cmpv;
                    r_out.current_position <= r_tpos;
                    r_out.compare_written <= 1'b1;
                    r_state <= S_OUT;
                end
                // walk channels one per cycle while the output is not stalled
                S_TICK: begin
                    if (w_tend) begin
                        if (!w_tstall) begin
                            if (r_have) r_out <= w_fin;
                            r_have  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else if (!w_tstall) begin
                        if (r_reg[w_tch]) begin
                            if (w_hit) begin
                                r_cmp[w_tch] <= '0;
                                if (w_rep) begin
                                    // release the held result, hold this one
                                    if (r_have) r_out <= r_hold;
                                    r_hold <= '{ST_OK, 8'(r_idx), 1'b1, 16'd0,
                                                r_pos[w_tch], 1'b0};
                                    r_have <= 1'b1;
                                    r_nres <= r_nres + 4'd1;
                                end
                            end
                            if (r_tmo[w_tch] != '0)
                                r_tmo[w_tch] <= r_tmo[w_tch] - 16'd1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/servo_bank_pwm_controller.sv =====
// Servo bank PWM controller. Requests enter a two-entry queue and are carried
// out one at a time by a back end, which takes a new request only once its
// previous result has been accepted. A move runs the 33-step shift-subtract
// divider for pos*(max-min)/range, followed by a multiply, a scale and a
// reciprocal divide for the compare value; with a zero range the divider is
// skipped. A tick walks one channel per cycle, pausing while a result waits
// on the receiver. Configuration writes are taken any time and apply to every
// request the back end works on afterward, so write them only while no
// request is in flight.
`default_nettype none
module servo_bank_pwm_controller #(
    parameter int SERVO_COUNT = sbpwm_pkg::SERVO_COUNT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire sbpwm_pkg::t_in i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output sbpwm_pkg::t_out     o_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [15:0]          i_cfg_data
);
    import sbpwm_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_qv, w_qr, w_busy;

    assign o_cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse_us <= 16'd1000;
            r_cfg.max_pulse_us <= 16'd2000;
            r_cfg.pwm_frequency_hz <= 10'd300;
            r_cfg.position_range <= 16'd1000;
            r_cfg.timeout_ticks <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN:     r_cfg.min_pulse_us <= i_cfg_data;
                CFG_MAX:     r_cfg.max_pulse_us <= i_cfg_data;
                CFG_FREQ:    r_cfg.pwm_frequency_hz <= i_cfg_data[9:0];
                CFG_RANGE:   r_cfg.position_range <= i_cfg_data;
                CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbpwm_front #(.SERVO_COUNT(SERVO_COUNT), .DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_cmd)
    );

    sbpwm_back #(.SERVO_COUNT(SERVO_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_valid(w_qv), .o_ready(w_qr),
        .i_cmd(w_cmd), .o_valid, .i_ready, .o_data, .o_busy(w_busy)
    );

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.last)
        else $error("error result not last");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> !o_valid)
        else $error("result while idle");
endmodule
`default_nettype wire
